[sv/keeloq_hopping_code_decrypt_macros.svh]
// Assertion macros used by the KeeLoq decryptor controller.
`ifndef KEELOQ_HOPPING_CODE_DECRYPT_MACROS_SVH
`define KEELOQ_HOPPING_CODE_DECRYPT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define KQD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kqd assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define KQD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kqd assertion failed");

`endif

[sv/kqd_pkg.sv]
// Shared constants, types and key derivation for the KeeLoq decryptor.
package kqd_pkg;

  localparam int ROUND_COUNT = 528;

  // Round counter also supplies the 6-bit key bit index.
  localparam int CNT_W = ($clog2(ROUND_COUNT) > 6) ? $clog2(ROUND_COUNT) : 6;
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(ROUND_COUNT - 1);

  localparam logic [31:0] NLF_TABLE   = 32'h3A5C742E;
  // Bytes 0..7 = 19 28 37 46 50 AF BE CD, byte 0 in the low bits.
  localparam logic [63:0] BUILTIN_KEY = 64'hCDBEAF50_46372819;

  typedef struct packed {
    logic load;  // capture input word and key, arm the round counter
    logic step;  // run one decryption round
  } cmd_t;

  typedef struct packed {
    logic last;  // the round in progress is the final one
  } sts_t;

  function automatic logic [63:0] derive_key(input logic [31:0] seed);
    logic [63:0] key;
    if (seed == 32'd0) begin
      key = BUILTIN_KEY;
    end else begin
      key[7:0]   = seed[31:24];
      key[15:8]  = seed[23:16];
      key[23:16] = seed[15:8];
      key[31:24] = seed[7:0];
      // Upper bytes drop the top bit of each seed byte.
      key[39:32] = {seed[30:24], 1'b0};
      key[47:40] = {seed[22:16], 1'b0};
      key[55:48] = {seed[14:8], 1'b0};
      key[63:56] = {seed[6:0], 1'b0};
    end
    return key;
  endfunction

endpackage

[sv/kqd_datapath.sv]
// Datapath: seed register, key register, round counter and the round unit.
module kqd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                key_seed_we,
  input  logic [31:0]         key_seed,
  input  logic [31:0]         cipher_word,
  input  kqd_pkg::cmd_t       cmd,
  output kqd_pkg::sts_t       sts,
  output logic [31:0]         plain_word
);

  logic [31:0]                seed;
  logic [63:0]                key;
  logic [kqd_pkg::CNT_W-1:0]  cnt;
  logic [31:0]                word;
  logic [31:0]                word_next;
  logic [4:0]                 nlf_idx;
  logic                       new_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= 32'd0;
    end else if (key_seed_we) begin
      seed <= key_seed;
    end
  end

  always_comb begin
    nlf_idx   = {word[30], word[25], word[19], word[8], word[0]};
    new_bit   = kqd_pkg::NLF_TABLE[nlf_idx] ^ word[15] ^ word[31] ^ key[cnt[5:0]];
    word_next = {word[30:0], new_bit};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word <= cipher_word;
      key  <= kqd_pkg::derive_key(seed);
      cnt  <= kqd_pkg::CNT_INIT;
    end else if (cmd.step) begin
      word <= word_next;
      cnt  <= cnt - kqd_pkg::CNT_W'(1);
    end
  end

  assign sts.last   = (cnt == '0);
  assign plain_word = word;

endmodule

[sv/kqd_ctrl.sv]
// Controller: sequences load, round steps and the result strobe.
`include "keeloq_hopping_code_decrypt_macros.svh"

module kqd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kqd_pkg::sts_t  sts,
  output kqd_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = (state == S_RUN);
  assign accept = start && !busy;
  assign done   = (state == S_DONE);

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    unique case (state)
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RUN: begin
        cmd.step = 1'b1;
        if (sts.last) begin
          state_next = S_DONE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `KQD_ASSERT_NOW(a_load_only_on_accept, cmd.load, accept && !cmd.step)
  `KQD_ASSERT_NEXT(a_accept_goes_busy, accept, busy && !done)
  `KQD_ASSERT_NEXT(a_last_round_done, busy && sts.last, done)
  `KQD_ASSERT_NEXT(a_done_single_cycle, done, !done)

endmodule

[sv/keeloq_hopping_code_decrypt.sv]
// KeeLoq decryptor: 528 rounds, one per clock on a single round unit.
// Result: done and plain_word are registered and rise once the final round has run.
// A new start is taken in the done cycle; start is ignored while busy.
// The round unit and its round counter step each code through all its rounds.
// Reset (rst, synchronous): controller idle, key seed cleared to zero.
// done is a one-cycle strobe; the receiver cannot stall.
module keeloq_hopping_code_decrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        key_seed_we,
  input  logic [31:0] key_seed,
  input  logic        start,
  input  logic [31:0] cipher_word,
  output logic        busy,
  output logic        done,
  output logic [31:0] plain_word
);

  kqd_pkg::cmd_t cmd;
  kqd_pkg::sts_t sts;

  kqd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  kqd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .key_seed_we (key_seed_we),
    .key_seed    (key_seed),
    .cipher_word (cipher_word),
    .cmd         (cmd),
    .sts         (sts),
    .plain_word  (plain_word)
  );

endmodule

[bench/keeloq_hopping_code_decrypt_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the KeeLoq decryptor: directed and random codes under several key seeds.
module keeloq_hopping_code_decrypt_tb;

  localparam int ROUNDS = 528;
  localparam logic [31:0] NLF_BITS = 32'h3A5C742E;
  // Fixed key, byte 0 in the low bits.
  localparam logic [63:0] FIXED_KEY =
    {8'hCD, 8'hBE, 8'hAF, 8'h50, 8'h46, 8'h37, 8'h28, 8'h19};
  localparam int MAX_GAP = 10;
  localparam int RAND_PHASES = 10;
  localparam int CODES_PER_PHASE = 111;
  localparam int N_EDGE_CODES = 14;
  localparam logic [31:0] EDGE_CODES [N_EDGE_CODES] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00000001, 32'h80000000,
    32'h7FFFFFFF, 32'hFFFFFFFE, 32'hAAAAAAAA, 32'h55555555,
    32'h40000000, 32'h02000000, 32'h00080000, 32'h00000100,
    32'h00008000, 32'h42088101
  };
  localparam longint CYCLE_LIMIT =
    64'd4 * (RAND_PHASES * CODES_PER_PHASE + 25) * (ROUNDS + MAX_GAP + 8) + 64'd10000;

  class plain_tracker;
    logic [31:0] seed;
    logic [31:0] plain_expected[$];
    int errors;
    int checked;

    function new();
      seed = 32'd0;
      errors = 0;
      checked = 0;
    endfunction

    function logic [63:0] key_of(logic [31:0] s);
      logic [63:0] key;
      logic [7:0] kb;
      if (s == 32'd0) return FIXED_KEY;
      for (int b = 0; b < 4; b++) begin
        kb = s[8*(3-b) +: 8];
        key[8*b +: 8] = kb;
        // Top bit of each seed byte falls off in the upper half.
        key[8*(b+4) +: 8] = {kb[6:0], 1'b0};
      end
      return key;
    endfunction

    function logic [31:0] decrypt_hop(logic [31:0] code);
      logic [63:0] key;
      logic [31:0] w;
      logic [4:0] sel;
      logic nb;
      int kidx;
      key = key_of(seed);
      w = code;
      for (int r = 0; r < ROUNDS; r++) begin
        sel = {w[30], w[25], w[19], w[8], w[0]};
        kidx = (ROUNDS - 1 - r) % 64;
        nb = NLF_BITS[sel] ^ w[15] ^ w[31] ^ key[kidx];
        w = {w[30:0], nb};
      end
      return w;
    endfunction

    function void note_cipher(logic [31:0] code);
      plain_expected.push_back(decrypt_hop(code));
    endfunction

    function void check_plain(logic [31:0] got);
      logic [31:0] want;
      if (plain_expected.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected plain_word: expected none, actual %08h", $time, got);
        return;
      end
      want = plain_expected.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        $display("%0t ERROR plain_word: expected %08h, actual %08h", $time, want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        key_seed_we;
  logic [31:0] key_seed;
  logic        start;
  logic [31:0] cipher_word;
  logic        busy;
  logic        done;
  logic [31:0] plain_word;

  plain_tracker board;
  int next_gap;
  bit no_idle;
  int codes_sent;
  int seeds_loaded;
  longint cycles;

  keeloq_hopping_code_decrypt i_dut (
    .clk         (clk),
    .rst         (rst),
    .key_seed_we (key_seed_we),
    .key_seed    (key_seed),
    .start       (start),
    .cipher_word (cipher_word),
    .busy        (busy),
    .done        (done),
    .plain_word  (plain_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) board.check_plain(plain_word);
  end

  // Hold start across back-to-back codes; drop it only before a gap or a phase end.
  task automatic send_code(input logic [31:0] code, input bit more);
    repeat (next_gap) @(posedge clk);
    start <= 1'b1;
    cipher_word <= code;
    do @(posedge clk); while (busy);
    board.note_cipher(code);
    codes_sent++;
    next_gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (next_gap != 0 || !more) begin
      start <= 1'b0;
      cipher_word <= $urandom;
    end
  endtask

  task automatic drain();
    while (board.plain_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_seed(input logic [31:0] s);
    key_seed_we <= 1'b1;
    key_seed <= s;
    @(posedge clk);
    key_seed_we <= 1'b0;
    key_seed <= $urandom;
    board.seed = s;
    seeds_loaded++;
  endtask

  initial begin
    logic [31:0] s;
    board = new();
    cycles = 0;
    codes_sent = 0;
    seeds_loaded = 0;
    no_idle = 1'b0;
    rst <= 1'b1;
    start <= 1'b0;
    cipher_word <= 32'd0;
    key_seed_we <= 1'b0;
    key_seed <= 32'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    next_gap = $urandom_range(0, MAX_GAP);

    // Reset seed selects the fixed key.
    for (int i = 0; i < N_EDGE_CODES; i++) send_code(EDGE_CODES[i], i != N_EDGE_CODES - 1);
    drain();

    // Every seed byte has its top bit set: the upper key half goes to zero.
    load_seed(32'h80808080);
    send_code(32'h00000000, 1'b1);
    send_code(32'hFFFFFFFF, 1'b1);
    send_code($urandom, 1'b1);
    send_code($urandom, 1'b0);
    drain();

    load_seed(32'hFFFFFFFF);
    send_code(32'h00000000, 1'b1);
    send_code(32'hFFFFFFFF, 1'b1);
    send_code(32'h42088101, 1'b0);
    drain();

    load_seed(32'h00000001);
    send_code(32'h00000000, 1'b1);
    send_code(32'hFFFFFFFF, 1'b0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: s = 32'd0;
        1: s = 32'hFFFFFFFF;
        2: s = 32'h00000001;
        3: s = {8'($urandom_range(0, 255)), 24'd0};
        default: s = $urandom;
      endcase
      load_seed(s);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < CODES_PER_PHASE; i++)
        send_code($urandom, i != CODES_PER_PHASE - 1);
      drain();
    end

    repeat (ROUNDS + 16) @(posedge clk);
    $display("Ran %0d hopping codes through %0d seed loads plus the reset key.",
             codes_sent, seeds_loaded);
    $display("Compared %0d plaintext words; %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0 && board.plain_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
